### hw/rtl/flsa_pkg.sv
`default_nettype none

package flsa_pkg;

   localparam int unsigned POOL_SLOTS_DEFAULT = 64;
   localparam int unsigned SLOT_W             = 8;
   localparam int unsigned LINK_W             = 9;

   // End of list: bit 8 set, which no slot index can reach
   localparam logic [LINK_W-1:0] LINK_END = 9'h100;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_EMPTY = 2'd1;
   localparam logic [1:0] STATUS_RANGE = 2'd2;

   typedef struct packed {
      logic              command;
      logic [SLOT_W-1:0] slot_index;
   } req_type;

   typedef struct packed {
      logic [SLOT_W-1:0] granted_slot;
      logic [1:0]        status;
   } rsp_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
   } link_rd_type;

   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

endpackage

`default_nettype wire

### hw/rtl/flsa_link_mem.sv
`default_nettype none

module flsa_link_mem #(
   parameter int unsigned POOL_SLOTS = flsa_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire                         clock,
   input  wire                         reset,
   input  flsa_pkg::link_rd_type       rd,
   input  flsa_pkg::link_wr_type       wr,
   output logic [flsa_pkg::LINK_W-1:0] rd_data
);
   import flsa_pkg::*;

   localparam int unsigned AddrW = (POOL_SLOTS > 1) ? $clog2(POOL_SLOTS) : 1;

   logic [LINK_W-1:0]     link_mem [POOL_SLOTS];
   logic [POOL_SLOTS-1:0] written_ff;
   logic [POOL_SLOTS-1:0] written_in;
   logic [LINK_W-1:0]     mem_q_ff;
   logic                  hit_ff;
   logic [LINK_W-1:0]     dflt_ff;
   logic [LINK_W-1:0]     dflt_in;
   logic [AddrW-1:0]      rd_addr;
   logic [AddrW-1:0]      wr_addr;

   assign rd_addr = rd.addr[AddrW-1:0];
   assign wr_addr = wr.addr[AddrW-1:0];

   // Power-up chain for entries never written: next slot, last one ends the list
   always_comb begin
      if (rd_addr == AddrW'(POOL_SLOTS - 1)) begin
         dflt_in = LINK_END;
      end else begin
         dflt_in = LINK_W'(rd_addr) + LINK_W'(1);
      end
   end

   always_comb begin
      written_in          = written_ff;
      written_in[wr_addr] = 1'b1;
   end

   always_ff @(posedge clock) begin
      if (wr.en) begin
         link_mem[wr_addr] <= wr.data;
      end
      if (rd.en) begin
         mem_q_ff <= link_mem[rd_addr];
         hit_ff   <= written_ff[rd_addr];
         dflt_ff  <= dflt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff <= '0;
      end else if (wr.en) begin
         written_ff <= written_in;
      end
   end

   assign rd_data = hit_ff ? mem_q_ff : dflt_ff;

endmodule

`default_nettype wire

### hw/rtl/flsa_rsp_reg.sv
`default_nettype none

module flsa_rsp_reg (
   input  wire               clock,
   input  wire               reset,
   input  wire               load,
   input  flsa_pkg::rsp_type rsp_in,
   input  wire               rsp_stall,
   output logic              rsp_valid,
   output flsa_pkg::rsp_type rsp,
   output logic              can_load
);
   import flsa_pkg::*;

   logic    rsp_valid_ff;
   logic    rsp_valid_in;
   rsp_type rsp_ff;

   assign can_load     = !rsp_valid_ff || !rsp_stall;
   // Hold a stalled result, drop it once taken
   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

endmodule

`default_nettype wire

### hw/rtl/free_list_slot_allocator_top.sv
`default_nettype none

// Slot allocator over a pool of POOL_SLOTS slots kept as a linked free list:
// a head register and a one-entry-per-slot link memory. Allocate pops the head
// slot, free pushes the given slot; every request yields exactly one response.
// A request is accepted in ST_IDLE; an allocate then issues the link memory
// read of the head slot. ST_BUSY loads the response register and, on success,
// updates the head and writes the link back. A response waiting on rsp_stall
// holds ST_BUSY until the response register frees up. Right after reset the
// pool is the chain 0, 1, 2, ... with no clearing pass; per-slot written flags
// stand in for the power-up contents.
module free_list_slot_allocator_top #(
   parameter int unsigned POOL_SLOTS = flsa_pkg::POOL_SLOTS_DEFAULT
) (
   input  wire               clock,
   input  wire               reset,
   input  wire               req_valid,
   output logic              req_stall,
   input  flsa_pkg::req_type req,
   output logic              rsp_valid,
   input  wire               rsp_stall,
   output flsa_pkg::rsp_type rsp
);
   import flsa_pkg::*;

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_BUSY = 1'b1;

   logic              state_ff;
   logic              state_in;
   req_type           req_ff;
   logic [LINK_W-1:0] head_ff;
   logic [LINK_W-1:0] head_in;
   logic [LINK_W-1:0] rd_data;
   link_rd_type       link_rd;
   link_wr_type       link_wr;
   rsp_type           rsp_d;
   logic              accept;
   logic              head_ok;
   logic              idx_ok;
   logic              can_load;
   logic              finish;

   // Hold off requests while in reset or while a request is in flight
   assign req_stall = reset || (state_ff != ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign head_ok   = head_ff < LINK_W'(POOL_SLOTS);
   assign idx_ok    = {1'b0, req_ff.slot_index} < LINK_W'(POOL_SLOTS);
   assign finish    = (state_ff == ST_BUSY) && can_load;

   assign link_rd.en   = accept && (req.command == CMD_ALLOC) && head_ok;
   assign link_rd.addr = head_ff[SLOT_W-1:0];

   always_comb begin
      head_in      = head_ff;
      link_wr      = '0;
      rsp_d        = '0;
      rsp_d.status = STATUS_OK;
      if (req_ff.command == CMD_ALLOC) begin
         if (!head_ok) begin
            rsp_d.status = STATUS_EMPTY;
         end else begin
            head_in            = rd_data;
            link_wr.en         = finish;
            link_wr.addr       = head_ff[SLOT_W-1:0];
            link_wr.data       = LINK_END;
            rsp_d.granted_slot = head_ff[SLOT_W-1:0];
         end
      end else begin
         if (!idx_ok) begin
            rsp_d.status = STATUS_RANGE;
         end else begin
            head_in      = {1'b0, req_ff.slot_index};
            link_wr.en   = finish;
            link_wr.addr = req_ff.slot_index;
            link_wr.data = head_ff;
         end
      end
   end

   always_comb begin
      case (state_ff)
         ST_IDLE: state_in = accept ? ST_BUSY : ST_IDLE;
         ST_BUSY: state_in = finish ? ST_IDLE : ST_BUSY;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         head_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (finish) begin
            head_ff <= head_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff <= req;
      end
   end

   flsa_link_mem #(
      .POOL_SLOTS(POOL_SLOTS)
   ) u_link_mem (
      .clock  (clock),
      .reset  (reset),
      .rd     (link_rd),
      .wr     (link_wr),
      .rd_data(rd_data)
   );

   flsa_rsp_reg u_rsp_reg (
      .clock    (clock),
      .reset    (reset),
      .load     (finish),
      .rsp_in   (rsp_d),
      .rsp_stall(rsp_stall),
      .rsp_valid(rsp_valid),
      .rsp      (rsp),
      .can_load (can_load)
   );

endmodule

`default_nettype wire

### hw/rtl/flsa_checker.sv
`default_nettype none

module flsa_checker #(
   parameter int unsigned POOL_SLOTS = flsa_pkg::POOL_SLOTS_DEFAULT
) (
   input wire               clock,
   input wire               reset,
   input wire               req_valid,
   input wire               req_stall,
   input wire               rsp_valid,
   input wire               rsp_stall,
   input flsa_pkg::rsp_type rsp
);
   import flsa_pkg::*;

   // One request in flight: the cycle after an accept takes nothing
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request accepted while another is in flight");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
      else $error("stalled response changed");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp.status == STATUS_OK) || (rsp.status == STATUS_EMPTY)
                    || (rsp.status == STATUS_RANGE))
      else $error("unknown status code");

   a_fail_no_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp.status != STATUS_OK) |-> rsp.granted_slot == '0)
      else $error("slot reported on a failed request");

   a_slot_in_pool: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp.granted_slot} < LINK_W'(POOL_SLOTS))
      else $error("granted slot beyond pool");

endmodule

bind free_list_slot_allocator_top flsa_checker #(
   .POOL_SLOTS(POOL_SLOTS)
) u_flsa_checker (
   .clock    (clock),
   .reset    (reset),
   .req_valid(req_valid),
   .req_stall(req_stall),
   .rsp_valid(rsp_valid),
   .rsp_stall(rsp_stall),
   .rsp      (rsp)
);

`default_nettype wire

### sim/tb_top.sv
`default_nettype none

module tb_top;
   import flsa_pkg::*;

   localparam int unsigned POOL = POOL_SLOTS_DEFAULT;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_REQUESTS = 209;

   typedef struct {
      logic              command;
      logic [SLOT_W-1:0] slot_index;
      int                reps;
      bit                typed;
      logic [SLOT_W-1:0] want_slot;
      logic [1:0]        want_status;
   } dir_row_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp;

   // free-list mirror kept by the testbench
   logic [LINK_W-1:0] pool_link [POOL];
   logic [LINK_W-1:0] pool_head;

   rsp_type           pending [$];
   logic [SLOT_W-1:0] held_slots [$];
   rsp_type           head_want;
   int                errors = 0;
   int                idle_pct = 0;
   int                stall_pct = 0;

   // directed requests; the reps row drains what is left of the pool
   dir_row_type dir_rows [18] = '{
      '{CMD_ALLOC, 8'h00, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'hFF, 1,  1'b1, 8'd1, STATUS_OK},
      '{CMD_FREE,  8'h00, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'h5A, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_FREE,  8'hFF, 1,  1'b1, 8'd0, STATUS_RANGE},
      '{CMD_FREE,  8'h40, 1,  1'b1, 8'd0, STATUS_RANGE},
      '{CMD_FREE,  8'h80, 1,  1'b1, 8'd0, STATUS_RANGE},
      '{CMD_FREE,  8'h00, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'hA5, 63, 1'b0, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'h00, 1,  1'b1, 8'd0, STATUS_EMPTY},
      '{CMD_ALLOC, 8'hFF, 1,  1'b1, 8'd0, STATUS_EMPTY},
      '{CMD_FREE,  8'h3F, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_FREE,  8'h3F, 1,  1'b1, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'h00, 1,  1'b0, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'h00, 1,  1'b0, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'h00, 1,  1'b1, 8'd0, STATUS_EMPTY},
      '{CMD_FREE,  8'h2A, 1,  1'b0, 8'd0, STATUS_OK},
      '{CMD_ALLOC, 8'hC3, 1,  1'b0, 8'd0, STATUS_OK}
   };

   free_list_slot_allocator_top #(.POOL_SLOTS(POOL)) DUT (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req       (req),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp       (rsp)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   function automatic rsp_type predict_pool(input req_type r);
      rsp_type           o;
      logic [LINK_W-1:0] nxt;
      o.granted_slot = '0;
      o.status       = STATUS_OK;
      if (r.command == CMD_ALLOC) begin
         if (pool_head >= POOL) begin
            o.status = STATUS_EMPTY;
         end else begin
            nxt = pool_link[pool_head];
            pool_link[pool_head] = LINK_END;
            o.granted_slot = pool_head[SLOT_W-1:0];
            pool_head = nxt;
         end
      end else if (r.slot_index >= POOL) begin
         o.status = STATUS_RANGE;
      end else begin
         pool_link[r.slot_index] = pool_head;
         pool_head = {1'b0, r.slot_index};
      end
      return o;
   endfunction

   task automatic send_request(input logic cmd, input logic [SLOT_W-1:0] idx,
                               input bit typed, input rsp_type typed_want);
      req_type r;
      rsp_type outcome;
      int      gap;
      r.command    = cmd;
      r.slot_index = idx;
      req_valid <= 1'b1;
      req       <= r;
      do @(posedge clock); while (req_stall);
      outcome = predict_pool(r);
      pending.push_back(typed ? typed_want : outcome);
      if (outcome.status == STATUS_OK) begin
         if (cmd == CMD_ALLOC) begin
            held_slots.push_back(outcome.granted_slot);
         end else begin
            for (int k = 0; k < held_slots.size(); k++) begin
               if (held_slots[k] == idx) begin
                  held_slots.delete(k);
                  break;
               end
            end
         end
      end
      gap = 0;
      while ($urandom_range(99) < idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // drive the response stall
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending.size() == 0) begin
            $display("%0t: response with none outstanding: granted_slot %0d status %0d",
                     $time, rsp.granted_slot, rsp.status);
            errors++;
         end else begin
            head_want = pending.pop_front();
            if (rsp.granted_slot !== head_want.granted_slot) begin
               $display("%0t: granted_slot expected %0d actual %0d",
                        $time, head_want.granted_slot, rsp.granted_slot);
               errors++;
            end
            if (rsp.status !== head_want.status) begin
               $display("%0t: status expected %0d actual %0d",
                        $time, head_want.status, rsp.status);
               errors++;
            end
         end
      end
   end

   initial begin
      int                alloc_pct;
      int                pick;
      logic [SLOT_W-1:0] idx;
      rsp_type           typed_want;

      for (int i = 0; i < POOL; i++) begin
         pool_link[i] = LINK_W'(i + 1);
      end
      pool_link[POOL-1] = LINK_END;
      pool_head = '0;

      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[i]) begin
         typed_want.granted_slot = dir_rows[i].want_slot;
         typed_want.status       = dir_rows[i].want_status;
         repeat (dir_rows[i].reps) begin
            send_request(dir_rows[i].command, dir_rows[i].slot_index,
                         dir_rows[i].typed, typed_want);
         end
      end

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         // hold off until the pipe is empty
         req_valid <= 1'b0;
         while (pending.size() != 0) @(posedge clock);
         case (p % 4)
            0: begin idle_pct = 0;  stall_pct = 0;  end
            1: begin idle_pct = 65; stall_pct = 0;  end
            2: begin idle_pct = 0;  stall_pct = 65; end
            default: begin idle_pct = 9; stall_pct = 9; end
         endcase
         // rotate the allocate share (70, 35, 55 percent) to drain and refill the pool
         alloc_pct = (p % 3 == 0) ? 70 : (p % 3 == 1) ? 35 : 55;
         repeat (PHASE_REQUESTS) begin
            if ($urandom_range(99) < alloc_pct) begin
               send_request(CMD_ALLOC, SLOT_W'($urandom_range(255)), 1'b0, '0);
            end else begin
               pick = $urandom_range(99);
               if (pick < 80 && held_slots.size() > 0) begin
                  idx = held_slots[$urandom_range(held_slots.size() - 1)];
               end else if (pick < 90) begin
                  idx = SLOT_W'($urandom_range(POOL - 1));
               end else begin
                  idx = SLOT_W'($urandom_range(255));
               end
               send_request(CMD_FREE, idx, 1'b0, '0);
            end
         end
      end

      req_valid <= 1'b0;
      while (pending.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

endmodule

`default_nettype wire
